### rtl/core/smoothing_filter_5x5_defines.svh
// ----------------------------------------------------------------------------
// smoothing_filter_5x5 assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SMOOTHING_FILTER_5X5_DEFINES_SVH
`define SMOOTHING_FILTER_5X5_DEFINES_SVH

`ifndef SYNTHESIS
`define SF5_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define SF5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SF5_ASSERT(lbl, clk, rst_n, prop, msg)
`define SF5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/sf5_pkg.sv
// ----------------------------------------------------------------------------
// sf5_pkg
// Shared types and constants of the 5x5 smoothing filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sf5_pkg;

    localparam int FW_BITS     = 11;
    localparam int FH_BITS     = 13;
    localparam int CFG_W       = 13;
    localparam int ROW_W       = 13;
    localparam int HEIGHT_MAX  = 4096;
    localparam int IN_PIX_W    = 16;
    localparam int OUT_W       = 21;
    localparam int OUT_TDATA_W = 24;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } t_mode;

    // kernel weights, row major, top row first
    localparam logic [1:0] KERN [5][5] = '{
        '{2'd0, 2'd1, 2'd1, 2'd1, 2'd0},
        '{2'd1, 2'd1, 2'd2, 2'd1, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd1, 2'd2, 2'd1, 2'd1},
        '{2'd0, 2'd1, 2'd1, 2'd1, 2'd0}
    };

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [4:0] rmask;
        logic [4:0] cmask;
    } t_tap_ctrl;

    typedef struct packed {
        logic s2_emit;
        logic s3_emit;
    } t_conv_stat;

endpackage

### rtl/core/sf5_line_store.sv
// ----------------------------------------------------------------------------
// sf5_line_store
// Four row banks; one written and all four read per request, read-first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sf5_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int PW        = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [1:0]                  i_wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  logic [PW-1:0]               i_wdata,
    output logic [3:0][PW-1:0]          o_rdata
);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PW-1:0] r_mem [MAX_WIDTH];
        logic [PW-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_wr_bank == 2'(b)) begin
                    r_mem[i_addr] <= i_wdata;
                end
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_rdata[b] = r_rd;
    end

endmodule

### rtl/core/sf5_conv.sv
// ----------------------------------------------------------------------------
// sf5_conv
// 5x5 window shift, masked weighted row sums, final sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sf5_conv #(
    parameter int PW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic                  i_valid,
    input  sf5_pkg::t_tap_ctrl    i_ctrl,
    input  logic [1:0]            i_rot,
    input  logic [3:0][PW-1:0]    i_rdata,
    input  logic [PW-1:0]         i_pix,
    output sf5_pkg::t_conv_stat   o_stat,
    output logic                  o_valid,
    output logic                  o_last,
    output logic [PW+4:0]         o_sum
);

    localparam int RSW = PW + 4;
    localparam int SW  = PW + 5;

    logic [PW-1:0]      w_col [5];
    logic [PW-1:0]      r_win [5][5];
    logic [PW-1:0]      n_win [5][5];
    logic               r_clear;
    logic               r_s2_emit;
    sf5_pkg::t_tap_ctrl r_s2_ctrl;
    logic [RSW-1:0]     w_row [5];
    logic [RSW-1:0]     r_s3_row [5];
    logic               r_s3_emit;
    logic               r_s3_last;

    // column entering the window: oldest row from bank rot
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_col[i] = i_rdata[i_rot + 2'(i)];
        end
        w_col[4] = i_pix;
    end

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_win[i][j] = r_clear ? '0 : r_win[i][j+1];
            end
            n_win[i][4] = w_col[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_win <= n_win;
        end
        r_s2_ctrl <= i_ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear   <= 1'b1;
            r_s2_emit <= 1'b0;
        end else begin
            if (i_restart) begin
                r_clear <= 1'b1;
            end else if (i_valid) begin
                r_clear <= i_ctrl.emit && i_ctrl.last;
            end
            r_s2_emit <= i_valid && i_ctrl.emit;
        end
    end

    // taps outside the frame drop out
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_row[i] = '0;
            for (int j = 0; j < 5; j++) begin
                if (r_s2_ctrl.rmask[i] && r_s2_ctrl.cmask[j]) begin
                    w_row[i] = w_row[i]
                             + RSW'(r_win[i][j]) * RSW'(sf5_pkg::KERN[i][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_row  <= w_row;
        r_s3_last <= r_s2_ctrl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_emit <= 1'b0;
        end else begin
            r_s3_emit <= r_s2_emit;
        end
    end

    always_comb begin
        o_sum = '0;
        for (int i = 0; i < 5; i++) begin
            o_sum = o_sum + SW'(r_s3_row[i]);
        end
    end

    assign o_valid        = r_s3_emit;
    assign o_last         = r_s3_last;
    assign o_stat.s2_emit = r_s2_emit;
    assign o_stat.s3_emit = r_s3_emit;

endmodule

### rtl/core/smoothing_filter_5x5.sv
// ----------------------------------------------------------------------------
// smoothing_filter_5x5
// Throughput: one request per cycle, sustained while results are taken.
// Path: stage 1, window, row-sum and queue registers follow the request that
//   completes a window, 2*W+2 requests after its pixel (W = width in use).
// Reset: width and height 1024, frame counters and window cleared; the line
//   stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "smoothing_filter_5x5_defines.svh"

module smoothing_filter_5x5 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_index,
    input  logic [sf5_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sf5_pkg::IN_PIX_W-1:0]      s_axis_tdata,   // [15:0] pixel_value
    input  logic [0:0]                        s_axis_tuser,   // [0] mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sf5_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [20:0] filtered_value
    output logic                              m_axis_tlast
);

    localparam int PW   = (PIXEL_BITS < sf5_pkg::IN_PIX_W) ? PIXEL_BITS : sf5_pkg::IN_PIX_W;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int PCW  = $clog2(2 * MAX_WIDTH + 3);
    localparam int RW   = sf5_pkg::ROW_W;
    localparam int FWB  = sf5_pkg::FW_BITS;
    localparam int FHB  = sf5_pkg::FH_BITS;
    localparam int OW   = sf5_pkg::OUT_W;
    localparam int DEP  = sf5_pkg::FIFO_DEPTH;
    localparam int AW   = sf5_pkg::FIFO_AW;

    typedef struct packed {
        logic          last;
        logic [OW-1:0] value;
    } t_out_entry;

    logic [FWB-1:0]      r_frame_width;
    logic [FHB-1:0]      r_frame_height;
    logic [RW-1:0]       r_in_row;
    logic [CW-1:0]       r_in_col;
    logic [RW-1:0]       r_out_row;
    logic [CW-1:0]       r_out_col;
    logic [PCW-1:0]      r_prime;

    logic [WW-1:0]       w_width;
    logic [RW-1:0]       w_height;
    logic [PCW-1:0]      w_thr;
    logic                w_draining;
    logic                w_is_drain;
    logic                w_take;
    logic                w_emit;
    logic                w_last;
    logic                w_row_end;
    logic [PW-1:0]       w_pix;
    sf5_pkg::t_tap_ctrl  w_ctrl;

    logic                r_s1_valid;
    sf5_pkg::t_tap_ctrl  r_s1_ctrl;
    logic [1:0]          r_s1_rot;
    logic [PW-1:0]       r_s1_pix;

    logic [3:0][PW-1:0]  w_rdata;
    sf5_pkg::t_conv_stat w_stat;
    logic                w_push;
    logic                w_push_last;
    logic [PW+4:0]       w_sum;

    t_out_entry          r_fifo [DEP];
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       r_rd_ptr;
    logic [AW:0]         r_fifo_cnt;
    logic                w_pop;
    logic [AW+1:0]       w_outstanding;

    // ---------------- frame geometry ----------------
    always_comb begin
        if (r_frame_width == '0) begin
            w_width = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_height = RW'(1);
        end else if (32'(r_frame_height) > sf5_pkg::HEIGHT_MAX) begin
            w_height = RW'(sf5_pkg::HEIGHT_MAX);
        end else begin
            w_height = RW'(r_frame_height);
        end
    end

    assign w_thr      = PCW'({w_width, 1'b0}) + PCW'(2);
    assign w_draining = r_in_row >= w_height;
    assign w_is_drain = sf5_pkg::t_mode'(s_axis_tuser[0]) == sf5_pkg::MODE_DRAIN;
    assign w_take     = s_axis_tvalid && s_axis_tready && (w_is_drain == w_draining);
    assign w_emit     = r_prime == w_thr;
    assign w_last     = ((r_out_row + RW'(1)) == w_height)
                     && ((WW'(r_out_col) + WW'(1)) == w_width);
    assign w_row_end  = (WW'(r_in_col) + WW'(1)) == w_width;
    assign w_pix      = w_draining ? '0 : s_axis_tdata[PW-1:0];

    always_comb begin
        w_ctrl.emit     = w_emit;
        w_ctrl.last     = w_last;
        w_ctrl.rmask[0] = r_out_row >= RW'(2);
        w_ctrl.rmask[1] = r_out_row >= RW'(1);
        w_ctrl.rmask[2] = 1'b1;
        w_ctrl.rmask[3] = ({1'b0, r_out_row} + (RW+1)'(1)) < {1'b0, w_height};
        w_ctrl.rmask[4] = ({1'b0, r_out_row} + (RW+1)'(2)) < {1'b0, w_height};
        w_ctrl.cmask[0] = r_out_col >= CW'(2);
        w_ctrl.cmask[1] = r_out_col >= CW'(1);
        w_ctrl.cmask[2] = 1'b1;
        w_ctrl.cmask[3] = ((WW+1)'(r_out_col) + (WW+1)'(1)) < (WW+1)'(w_width);
        w_ctrl.cmask[4] = ((WW+1)'(r_out_col) + (WW+1)'(2)) < (WW+1)'(w_width);
    end

    // ---------------- position counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FWB'(1024);
            r_frame_height <= FHB'(1024);
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_out_row      <= '0;
            r_out_col      <= '0;
            r_prime        <= '0;
        end else if (i_cfg_we) begin
            unique case (sf5_pkg::t_cfg_reg'(i_cfg_index))
                sf5_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FWB-1:0];
                sf5_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FHB-1:0];
                default: ;
            endcase
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_prime   <= '0;
        end else if (w_take) begin
            if (w_row_end) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + RW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
            if (!w_emit) begin
                r_prime <= r_prime + PCW'(1);
            end else if (w_last) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
                r_prime   <= '0;
            end else if ((WW'(r_out_col) + WW'(1)) == w_width) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + RW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_take && !i_cfg_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctrl <= w_ctrl;
        r_s1_rot  <= r_in_row[1:0];
        r_s1_pix  <= w_pix;
    end

    sf5_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .PW        (PW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_en      (w_take && !i_cfg_we),
        .i_wr_bank (r_in_row[1:0]),
        .i_addr    (r_in_col),
        .i_wdata   (w_pix),
        .o_rdata   (w_rdata)
    );

    sf5_conv #(
        .PW (PW)
    ) u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_valid   (r_s1_valid),
        .i_ctrl    (r_s1_ctrl),
        .i_rot     (r_s1_rot),
        .i_rdata   (w_rdata),
        .i_pix     (r_s1_pix),
        .o_stat    (w_stat),
        .o_valid   (w_push),
        .o_last    (w_push_last),
        .o_sum     (w_sum)
    );

    // ---------------- result queue ----------------
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign w_outstanding = (AW+2)'(r_fifo_cnt)
                         + (AW+2)'(r_s1_valid && r_s1_ctrl.emit)
                         + (AW+2)'(w_stat.s2_emit)
                         + (AW+2)'(w_stat.s3_emit);
    assign s_axis_tready = w_outstanding < (AW+2)'(DEP);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr].last  <= w_push_last;
            r_fifo[r_wr_ptr].value <= OW'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_fifo_cnt <= r_fifo_cnt + (AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_fifo_cnt <= r_fifo_cnt - (AW+1)'(1);
            end
        end
    end

    assign m_axis_tvalid = r_fifo_cnt != '0;
    assign m_axis_tdata  = {{(sf5_pkg::OUT_TDATA_W - OW){1'b0}}, r_fifo[r_rd_ptr].value};
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

    // ---------------- assertions ----------------
    `SF5_ASSERT(a_fifo_bound, i_clk, i_rst_n, r_fifo_cnt <= (AW+1)'(DEP), "result queue overflow")
    `SF5_ASSERT(a_push_room, i_clk, i_rst_n, !w_push || (r_fifo_cnt < (AW+1)'(DEP)) || w_pop, "push into full queue")
    `SF5_ASSERT(a_prime_bound, i_clk, i_rst_n, r_prime <= w_thr, "fill counter past threshold")
    `SF5_ASSERT_NEXT(a_restart, i_clk, i_rst_n, w_take && w_emit && w_last && !i_cfg_we, r_in_row == '0 && r_in_col == '0 && r_prime == '0, "frame did not restart after last result")

endmodule

### test/smoothing_filter_5x5_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothing_filter_5x5_test
// Sends pixel streams through the 5x5 filter. A short table of corner cases
// comes first, then an all-max 6x5 frame, many small random frames, and the
// widest and the tallest frame. Both stream sides stall at random. Results typed
// in the table are checked as typed, all others against a line-buffer model.
// ----------------------------------------------------------------------------

module smoothing_filter_5x5_test;
    import sf5_pkg::*;

    localparam int LINE_W       = 1024;
    localparam int PIX_W        = 16;
    localparam int VAL_W        = 21;
    localparam int FLUSH_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SMALL_ITEMS  = 1800;

    localparam logic [1:0] KERNEL [5][5] = '{
        '{2'd0, 2'd1, 2'd1, 2'd1, 2'd0},
        '{2'd1, 2'd1, 2'd2, 2'd1, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd1, 2'd2, 2'd1, 2'd1},
        '{2'd0, 2'd1, 2'd1, 2'd1, 2'd0}
    };

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             is_last;
    } t_filter_result;

    typedef struct packed {
        logic             is_cfg;
        t_cfg_reg         reg_sel;
        logic [CFG_W-1:0] cfg_data;
        t_mode            mode;
        logic [PIX_W-1:0] pixel;
        logic             typed;
        logic [VAL_W-1:0] typed_value;
        logic             typed_last;
    } t_stim_row;

    localparam int N_ROWS = 29;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        // 1x1 frame, both sizes written as zero
        '{1'b1, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 13'd0,    MODE_PIXEL, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'hFFFF, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b1, 21'd196605, 1'b1},
        // drain after the final result
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        // 3x2, width written with junk in the unused top bits
        '{1'b1, REG_FRAME_WIDTH,  13'h1803, MODE_PIXEL, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 13'd2,    MODE_PIXEL, 16'h0000, 1'b0, 21'd0,      1'b0},
        // partial frame, dropped by the next write
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h1234, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h8421, 1'b0, 21'd0,      1'b0},
        '{1'b1, REG_FRAME_HEIGHT, 13'd2,    MODE_PIXEL, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'hFFFF, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h0000, 1'b0, 21'd0,      1'b0},
        // drain inside the frame's pixels
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'hFFFF, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'hAAAA, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h5555, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'hFFFF, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h0001, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        // pixel while draining
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_PIXEL, 16'h7FFF, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0},
        '{1'b0, REG_FRAME_WIDTH,  13'd0,    MODE_DRAIN, 16'h0000, 1'b0, 21'd0,      1'b0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [0:0]             i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_PIX_W-1:0]    s_axis_tdata;   // [15:0] pixel_value
    logic [0:0]             s_axis_tuser;   // [0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [20:0] filtered_value
    logic                   m_axis_tlast;

    logic [PIX_W-1:0] pr_lines [4*LINE_W];
    logic [PIX_W-1:0] pr_win [5][5];
    int unsigned      pr_w_raw;
    int unsigned      pr_h_raw;
    int unsigned      pr_in_row;
    int unsigned      pr_in_col;
    int unsigned      pr_out_row;
    int unsigned      pr_out_col;

    t_filter_result filter_results [$];
    int             mismatches  = 0;
    int             cycle_count = 0;
    bit             sender_rush = 1'b0;
    bit             sink_rush   = 1'b0;

    smoothing_filter_5x5 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned width_in_use();
        if (pr_w_raw < 1) return 1;
        if (pr_w_raw > LINE_W) return LINE_W;
        return pr_w_raw;
    endfunction

    function automatic int unsigned height_in_use();
        if (pr_h_raw < 1) return 1;
        if (pr_h_raw > HEIGHT_MAX) return HEIGHT_MAX;
        return pr_h_raw;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) pr_win[i][j] = '0;
        end
        pr_in_row  = 0;
        pr_in_col  = 0;
        pr_out_row = 0;
        pr_out_col = 0;
    endfunction

    function automatic void apply_register(input t_cfg_reg sel, input logic [CFG_W-1:0] data);
        if (sel == REG_FRAME_WIDTH) begin
            pr_w_raw = data[FW_BITS-1:0];
        end else begin
            pr_h_raw = data[FH_BITS-1:0];
        end
        clear_window();
    endfunction

    // Line stores hold rows in_row-4..in_row-1; the window's center is the
    // pixel whose result is due next.
    function automatic bit predict_filter(input t_mode mode, input logic [PIX_W-1:0] pix,
                                          output bit used, output t_filter_result res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      pos;
        int unsigned      acc;
        int               rr;
        int               cc;
        logic [PIX_W-1:0] p;
        logic [PIX_W-1:0] col [5];
        w    = width_in_use();
        h    = height_in_use();
        res  = '0;
        used = ((mode == MODE_DRAIN) == (pr_in_row >= h));
        if (!used) return 1'b0;
        p = (mode == MODE_DRAIN) ? '0 : pix;
        c = (pr_in_col < LINE_W) ? pr_in_col : LINE_W - 1;
        for (int i = 0; i < 4; i++) col[i] = pr_lines[((pr_in_row + i) % 4) * LINE_W + c];
        col[4] = p;
        pr_lines[(pr_in_row % 4) * LINE_W + c] = p;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) pr_win[i][j] = pr_win[i][j+1];
            pr_win[i][4] = col[i];
        end
        pos = pr_in_row * w + pr_in_col;
        pr_in_col++;
        if (pr_in_col >= w) begin
            pr_in_col = 0;
            pr_in_row++;
        end
        if (pos < 2 * w + 2) return 1'b0;
        acc = 0;
        for (int dy = 0; dy < 5; dy++) begin
            rr = int'(pr_out_row) + dy - 2;
            if (rr >= 0 && rr < int'(h)) begin
                for (int dx = 0; dx < 5; dx++) begin
                    cc = int'(pr_out_col) + dx - 2;
                    if (cc >= 0 && cc < int'(w)) begin
                        acc += int'(KERNEL[dy][dx]) * int'(pr_win[dy][dx]);
                    end
                end
            end
        end
        res.value   = acc[VAL_W-1:0];
        res.is_last = (pr_out_row + 1 >= h) && (pr_out_col + 1 >= w);
        if (res.is_last) begin
            clear_window();
        end else begin
            pr_out_col++;
            if (pr_out_col >= w) begin
                pr_out_col = 0;
                pr_out_row++;
            end
        end
        return 1'b1;
    endfunction

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (filter_results.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_register(input t_cfg_reg sel, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_register(sel, data);
    endtask

    task automatic send_request(input t_mode mode, input logic [PIX_W-1:0] pix,
                                input bit typed, input t_filter_result typed_res,
                                output bit used, output bit frame_end);
        int             gap;
        bit             made;
        t_filter_result res;
        gap = sender_rush ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        made      = predict_filter(mode, pix, used, res);
        frame_end = made && res.is_last;
        if (typed) begin
            if (!made) begin
                report_mismatch("directed row gives no result");
            end else begin
                res = typed_res;
            end
        end
        if (made) filter_results.push_back(res);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input int style);
        case (style)
            1: return '1;
            2: return PIX_W'($urandom_range(0, 3));
            3: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic run_frame(input bit set_w, input bit set_h, input logic [FW_BITS-1:0] w_raw,
                             input logic [FH_BITS-1:0] h_raw, input int style,
                             input bit may_abandon, output int used_count);
        int unsigned    span;
        int unsigned    stop_at;
        int unsigned    n;
        bit             abandon;
        bit             used;
        bit             frame_end;
        logic [1:0]     spare;
        t_mode          mode;
        t_filter_result none;
        wait_idle();
        spare = $urandom_range(0, 3);
        if (set_w) write_register(REG_FRAME_WIDTH, {spare, w_raw});
        if (set_h) write_register(REG_FRAME_HEIGHT, h_raw);
        i_cfg_we <= 1'b0;
        sender_rush = ($urandom_range(0, 3) == 0);
        sink_rush   = ($urandom_range(0, 3) == 0);
        span    = width_in_use() * height_in_use() + 2 * width_in_use() + 2;
        abandon = may_abandon && ($urandom_range(0, 11) == 0);
        stop_at = $urandom_range(1, span - 1);
        none       = '0;
        n          = 0;
        used_count = 0;
        frame_end  = 1'b0;
        while (!frame_end && !(abandon && n == stop_at)) begin
            mode = (pr_in_row >= height_in_use()) ? MODE_DRAIN : MODE_PIXEL;
            if ($urandom_range(0, 19) == 0) begin
                mode = (mode == MODE_DRAIN) ? MODE_PIXEL : MODE_DRAIN;
            end
            if ($urandom_range(0, 149) == 0) wait_idle();
            send_request(mode, make_pixel(style), 1'b0, none, used, frame_end);
            n++;
            if (used) used_count++;
        end
        if (frame_end && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                send_request(MODE_DRAIN, make_pixel(0), 1'b0, none, used, frame_end);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_filter_result want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (filter_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d last %0b",
                                          m_axis_tdata[VAL_W-1:0], m_axis_tlast));
            end else begin
                want = filter_results.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== want.value) begin
                    report_mismatch($sformatf("filtered_value %0d, want %0d",
                                              m_axis_tdata[VAL_W-1:0], want.value));
                end
                if (m_axis_tlast !== want.is_last) begin
                    report_mismatch($sformatf("frame_last %0b, want %0b",
                                              m_axis_tlast, want.is_last));
                end
            end
        end
    end

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_rush ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        int                   used_total;
        int                   got;
        int                   sel;
        bit                   used;
        bit                   frame_end;
        logic [FW_BITS-1:0]   w_raw;
        logic [FH_BITS-1:0]   h_raw;
        t_filter_result       typed_res;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_FRAME_WIDTH;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_PIXEL;
        for (int i = 0; i < 4 * LINE_W; i++) pr_lines[i] = '0;
        pr_w_raw = 1024;
        pr_h_raw = 1024;
        clear_window();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_ROWS; k++) begin
            if (DIRECTED[k].is_cfg) begin
                if (k == 0 || !DIRECTED[k-1].is_cfg) wait_idle();
                write_register(DIRECTED[k].reg_sel, DIRECTED[k].cfg_data);
                if (k == N_ROWS - 1 || !DIRECTED[k+1].is_cfg) i_cfg_we <= 1'b0;
            end else begin
                typed_res = '{DIRECTED[k].typed_value, DIRECTED[k].typed_last};
                send_request(DIRECTED[k].mode, DIRECTED[k].pixel, DIRECTED[k].typed,
                             typed_res, used, frame_end);
            end
        end

        // all-max pixels so the full 27x sum shows up
        run_frame(1'b1, 1'b1, 11'd6, 13'd5, 1, 1'b0, got);
        used_total = got;
        while (used_total < SMALL_ITEMS) begin
            sel   = $urandom_range(0, 2);
            w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
            run_frame(sel != 1, sel != 0, w_raw, h_raw, $urandom_range(0, 3), 1'b1, got);
            used_total += got;
        end
        run_frame(1'b1, 1'b1, 11'd2047, 13'd1, 0, 1'b0, got);
        run_frame(1'b1, 1'b1, 11'd1, 13'd8191, 0, 1'b0, got);
        wait_idle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sf5_pkg.sv
rtl/core/sf5_line_store.sv
rtl/core/sf5_conv.sv
rtl/core/smoothing_filter_5x5.sv
test/smoothing_filter_5x5_test.sv
